[design/cartridge_rtc_counter_latch_defines.svh]
// Assertion macros used by the checker file of the clock block.
`ifndef CARTRIDGE_RTC_COUNTER_LATCH_DEFINES_SVH
`define CARTRIDGE_RTC_COUNTER_LATCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/crtc_pkg.sv]
package crtc_pkg;

    localparam int SubsecPerSec = 60;
    localparam int SecPerMin    = 60;
    localparam int MinPerHour   = 60;
    localparam int HourPerDay   = 24;
    localparam int DaysPerWrap  = 365;

    localparam int FlagStopBit  = 6;
    localparam int FlagCarryBit = 7;

    localparam logic [1:0] OpTick  = 2'd0;
    localparam logic [1:0] OpLatch = 2'd1;
    localparam logic [1:0] OpWrite = 2'd2;

    localparam logic [3:0] RegSec    = 4'd8;
    localparam logic [3:0] RegMin    = 4'd9;
    localparam logic [3:0] RegHour   = 4'd10;
    localparam logic [3:0] RegDayLow = 4'd11;
    localparam logic [3:0] RegFlags  = 4'd12;

    typedef logic [7:0] t_byte;

    function automatic logic [5:0] mod60(input t_byte b);
        t_byte r;
        if (b >= 8'd240) begin
            r = b - 8'd240;
        end else if (b >= 8'd180) begin
            r = b - 8'd180;
        end else if (b >= 8'd120) begin
            r = b - 8'd120;
        end else if (b >= 8'd60) begin
            r = b - 8'd60;
        end else begin
            r = b;
        end
        return r[5:0];
    endfunction

    // The quotient b * 171 / 4096 equals b / 24 exactly for every byte value.
    function automatic logic [4:0] mod24(input t_byte b);
        logic [15:0] prod;
        logic [3:0]  q;
        t_byte       r;
        prod = {8'd0, b} * 16'd171;
        q    = prod[15:12];
        r    = b - ({4'd0, q} * 8'd24);
        return r[4:0];
    endfunction

    function automatic logic [8:0] mod365(input logic [8:0] d);
        logic [8:0] r;
        if (d >= 9'(DaysPerWrap)) begin
            r = d - 9'(DaysPerWrap);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

[design/crtc_in_if.sv]
interface crtc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data;
    logic [3:0] reg_select;

    modport source (output valid, output opcode, output data, output reg_select,
                    input ready);
    modport sink (input valid, input opcode, input data, input reg_select,
                  output ready);
endinterface

[design/crtc_out_if.sv]
interface crtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] latched_seconds;
    logic [7:0] latched_minutes;
    logic [7:0] latched_hours;
    logic [8:0] latched_days;
    logic [7:0] latched_flags;
    logic       dirty;

    modport source (output valid, output latched_seconds, output latched_minutes,
                    output latched_hours, output latched_days, output latched_flags,
                    output dirty, input ready);
    modport sink (input valid, input latched_seconds, input latched_minutes,
                  input latched_hours, input latched_days, input latched_flags,
                  input dirty, output ready);
endinterface

[design/cartridge_rtc_counter_latch.sv]
// Real-time clock with a latch. Each input item is a tick, a latch write, a clock register
// write or an unused opcode that changes nothing, and each gives exactly one result item with
// the five latched registers and the dirty mark as they stand after that item. An item is
// captured in an input register and is worked through the counter cascade into the result
// register, so the block takes one item per cycle; it stalls only while a result waits at the
// output and the input register is full.
module cartridge_rtc_counter_latch
    import crtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    crtc_in_if.sink    i_in,
    crtc_out_if.source o_out
);

    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_data;
    logic [3:0] r_sel;

    logic       r_out_valid;
    logic [7:0] r_out_sec;
    logic [7:0] r_out_min;
    logic [7:0] r_out_hour;
    logic [8:0] r_out_day;
    logic [7:0] r_out_flags;
    logic       r_out_dirty;

    logic [5:0] r_sub, n_sub;
    logic [5:0] r_sec, n_sec;
    logic [5:0] r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [8:0] r_day, n_day;
    logic [7:0] r_flags, n_flags;
    logic       r_latch_bit, n_latch_bit;
    logic [8:0] r_l_sec, n_l_sec;
    logic [8:0] r_l_min, n_l_min;
    logic [8:0] r_l_hour, n_l_hour;
    logic [8:0] r_l_day, n_l_day;
    logic [8:0] r_l_flags, n_l_flags;
    logic       r_dirty, n_dirty;

    logic adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_comb begin
        n_sub       = r_sub;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_day       = r_day;
        n_flags     = r_flags;
        n_latch_bit = r_latch_bit;
        n_l_sec     = r_l_sec;
        n_l_min     = r_l_min;
        n_l_hour    = r_l_hour;
        n_l_day     = r_l_day;
        n_l_flags   = r_l_flags;
        n_dirty     = r_dirty;
        unique case (r_op)
            OpTick: begin
                if (!r_flags[FlagStopBit]) begin
                    if (r_sub < 6'(SubsecPerSec - 1)) begin
                        n_sub = r_sub + 6'd1;
                    end else begin
                        n_sub = '0;
                        if (r_sec < 6'(SecPerMin - 1)) begin
                            n_sec = r_sec + 6'd1;
                        end else begin
                            n_sec = '0;
                            if (r_min < 6'(MinPerHour - 1)) begin
                                n_min = r_min + 6'd1;
                            end else begin
                                n_min = '0;
                                if (r_hour < 5'(HourPerDay - 1)) begin
                                    n_hour = r_hour + 5'd1;
                                end else begin
                                    n_hour = '0;
                                    if (r_day < 9'(DaysPerWrap - 1)) begin
                                        n_day = r_day + 9'd1;
                                    end else begin
                                        n_day = '0;
                                        n_flags[FlagCarryBit] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            OpLatch: begin
                if (r_data[0] && !r_latch_bit) begin
                    n_l_sec   = {3'd0, r_sec};
                    n_l_min   = {3'd0, r_min};
                    n_l_hour  = {4'd0, r_hour};
                    n_l_day   = r_day;
                    n_l_flags = {1'b0, r_flags};
                end
                n_latch_bit = r_data[0];
            end
            OpWrite: begin
                n_dirty = 1'b1;
                unique case (r_sel)
                    RegSec: begin
                        n_l_sec = {1'b0, r_data};
                        n_sec   = mod60(r_data);
                    end
                    RegMin: begin
                        n_l_min = {1'b0, r_data};
                        n_min   = mod60(r_data);
                    end
                    RegHour: begin
                        n_l_hour = {1'b0, r_data};
                        n_hour   = mod24(r_data);
                    end
                    RegDayLow: begin
                        n_l_day = {1'b0, r_data};
                        n_day   = mod365({r_day[8], r_data});
                    end
                    RegFlags: begin
                        n_l_flags = {1'b0, r_data};
                        n_flags   = r_data;
                        n_day     = mod365({r_data[0], r_day[7:0]});
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sub       <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= '0;
            r_flags     <= '0;
            r_latch_bit <= 1'b0;
            r_l_sec     <= '0;
            r_l_min     <= '0;
            r_l_hour    <= '0;
            r_l_day     <= '0;
            r_l_flags   <= '0;
            r_dirty     <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_sub       <= n_sub;
                r_sec       <= n_sec;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_day       <= n_day;
                r_flags     <= n_flags;
                r_latch_bit <= n_latch_bit;
                r_l_sec     <= n_l_sec;
                r_l_min     <= n_l_min;
                r_l_hour    <= n_l_hour;
                r_l_day     <= n_l_day;
                r_l_flags   <= n_l_flags;
                r_dirty     <= n_dirty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.opcode;
            r_data <= i_in.data;
            r_sel  <= i_in.reg_select;
        end
        if (adv) begin
            r_out_sec   <= n_l_sec[7:0];
            r_out_min   <= n_l_min[7:0];
            r_out_hour  <= n_l_hour[7:0];
            r_out_day   <= n_l_day;
            r_out_flags <= n_l_flags[7:0];
            r_out_dirty <= n_dirty;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.latched_seconds = r_out_sec;
    assign o_out.latched_minutes = r_out_min;
    assign o_out.latched_hours   = r_out_hour;
    assign o_out.latched_days    = r_out_day;
    assign o_out.latched_flags   = r_out_flags;
    assign o_out.dirty           = r_out_dirty;

endmodule

[design/crtc_checker.sv]
`include "cartridge_rtc_counter_latch_defines.svh"

module crtc_checker
    import crtc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_seconds,
    input logic [8:0] i_out_days,
    input logic       i_out_dirty
);

    `CRTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_seconds) && $stable(i_out_days) && $stable(i_out_dirty), "stalled result item changed")
    `CRTC_ASSERT_NOW(a_day_range, i_clk, i_rst_n, i_out_valid, i_out_days < 9'(DaysPerWrap), "latched day count out of range")
    `CRTC_ASSERT_NEXT(a_dirty_sticky, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_dirty, !i_out_valid || i_out_dirty, "dirty mark cleared")
    `CRTC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

endmodule

bind cartridge_rtc_counter_latch crtc_checker u_crtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_seconds (o_out.latched_seconds),
    .i_out_days    (o_out.latched_days),
    .i_out_dirty   (o_out.dirty)
);

[tb/tb_cartridge_rtc_counter_latch.sv]
`timescale 1ns / 1ps

import crtc_pkg::*;

typedef struct packed {
    logic [7:0] secs;
    logic [7:0] mins;
    logic [7:0] hours;
    logic [8:0] days;
    logic [7:0] flags;
    logic       dirty;
} latched_view_t;

localparam logic [1:0] OpUnused = 2'd3;

class rtc_tracker;
    bit [5:0] sub_ticks;
    bit [5:0] live_sec;
    bit [5:0] live_min;
    bit [4:0] live_hour;
    bit [8:0] live_day;
    bit [7:0] live_flags;
    bit       latch_level;
    bit [8:0] held [5];
    bit       dirty_seen;

    latched_view_t pending_views[$];

    int mismatches;
    int results_seen;
    int ticks;
    int latches;
    int writes;
    int unused_ops;
    int day_wraps;

    task report(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function void advance_tick();
        if (live_flags[FlagStopBit]) begin
            return;
        end
        sub_ticks = sub_ticks + 1;
        if (sub_ticks < SubsecPerSec) begin
            return;
        end
        sub_ticks = 0;
        live_sec = live_sec + 1;
        if (live_sec < SecPerMin) begin
            return;
        end
        live_sec = 0;
        live_min = live_min + 1;
        if (live_min < MinPerHour) begin
            return;
        end
        live_min = 0;
        live_hour = live_hour + 1;
        if (live_hour < HourPerDay) begin
            return;
        end
        live_hour = 0;
        live_day = live_day + 1;
        if (live_day >= DaysPerWrap) begin
            live_day = 0;
            live_flags[FlagCarryBit] = 1'b1;
            day_wraps++;
        end
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] data, logic [3:0] sel);
        latched_view_t view;
        case (op)
            OpTick: begin
                ticks++;
                advance_tick();
            end
            OpLatch: begin
                latches++;
                if (data[0] && !latch_level) begin
                    held[0] = {3'd0, live_sec};
                    held[1] = {3'd0, live_min};
                    held[2] = {4'd0, live_hour};
                    held[3] = live_day;
                    held[4] = {1'b0, live_flags};
                end
                latch_level = data[0];
            end
            OpWrite: begin
                writes++;
                case (sel)
                    RegSec: begin
                        held[0] = {1'b0, data};
                        live_sec = 6'(data % SecPerMin);
                    end
                    RegMin: begin
                        held[1] = {1'b0, data};
                        live_min = 6'(data % MinPerHour);
                    end
                    RegHour: begin
                        held[2] = {1'b0, data};
                        live_hour = 5'(data % HourPerDay);
                    end
                    RegDayLow: begin
                        held[3] = {1'b0, data};
                        live_day = 9'({live_day[8], data} % DaysPerWrap);
                    end
                    RegFlags: begin
                        held[4] = {1'b0, data};
                        live_flags = data;
                        live_day = 9'({data[0], live_day[7:0]} % DaysPerWrap);
                    end
                    default: begin
                    end
                endcase
                dirty_seen = 1'b1;
            end
            default: begin
                unused_ops++;
            end
        endcase
        view.secs  = held[0][7:0];
        view.mins  = held[1][7:0];
        view.hours = held[2][7:0];
        view.days  = held[3];
        view.flags = held[4][7:0];
        view.dirty = dirty_seen;
        pending_views.push_back(view);
    endfunction

    task check_view(latched_view_t got);
        latched_view_t want;
        if (pending_views.size() == 0) begin
            report("result item arrived with no item outstanding");
            return;
        end
        want = pending_views.pop_front();
        results_seen++;
        if (got.secs !== want.secs) begin
            report($sformatf("seconds got %0d, expected %0d", got.secs, want.secs));
        end
        if (got.mins !== want.mins) begin
            report($sformatf("minutes got %0d, expected %0d", got.mins, want.mins));
        end
        if (got.hours !== want.hours) begin
            report($sformatf("hours got %0d, expected %0d", got.hours, want.hours));
        end
        if (got.days !== want.days) begin
            report($sformatf("days got %0d, expected %0d", got.days, want.days));
        end
        if (got.flags !== want.flags) begin
            report($sformatf("flags got 0x%02h, expected 0x%02h", got.flags, want.flags));
        end
        if (got.dirty !== want.dirty) begin
            report($sformatf("dirty got %0b, expected %0b", got.dirty, want.dirty));
        end
    endtask
endclass

module tb_cartridge_rtc_counter_latch;

    localparam int RandomItems = 1600;

    logic i_clk;
    logic i_rst_n;

    crtc_in_if  in_if ();
    crtc_out_if out_if ();

    cartridge_rtc_counter_latch uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rtc_tracker tracker = new();

    int burst_left;
    int items_sent;
    int cyc_count;
    int stall_mode;
    int stall_left;
    bit take;
    latched_view_t seen_view;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc_count = cyc_count + 1;
        if (cyc_count % 300 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: take = 1'b1;
            1: take = ($urandom_range(0, 3) != 0);
            2: take = (cyc_count % 7) > 1;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    take = 1'b0;
                end else begin
                    take = 1'b1;
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(1, 12);
                    end
                end
            end
        endcase
        out_if.ready <= take;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.note_item(in_if.opcode, in_if.data, in_if.reg_select);
            end
            if (out_if.valid && out_if.ready) begin
                seen_view.secs  = out_if.latched_seconds;
                seen_view.mins  = out_if.latched_minutes;
                seen_view.hours = out_if.latched_hours;
                seen_view.days  = out_if.latched_days;
                seen_view.flags = out_if.latched_flags;
                seen_view.dirty = out_if.dirty;
                tracker.check_view(seen_view);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [3:0] sel);
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.data       <= data;
        in_if.reg_select <= sel;
        do @(posedge i_clk); while (!in_if.ready);
        if (op != OpUnused) begin
            items_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(0, 15);
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (tracker.pending_views.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(OpTick, 8'($urandom_range(0, 255)),
                                 4'($urandom_range(0, 15)));
    endtask

    task automatic latch_snapshot();
        send_item(OpLatch, {7'($urandom_range(0, 127)), 1'b0}, 4'($urandom_range(0, 15)));
        send_item(OpLatch, {7'($urandom_range(0, 127)), 1'b1}, 4'($urandom_range(0, 15)));
    endtask

    // Load the counters just short of a rollover, then tick across it and latch.
    task automatic run_rollover();
        logic [7:0] flag_byte;
        logic [7:0] day_low;
        flag_byte = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) == 0),
                     5'($urandom_range(0, 31)), 1'($urandom_range(0, 3) != 0)};
        day_low = ($urandom_range(0, 2) != 0) ? 8'h6C : 8'($urandom_range(0, 255));
        send_item(OpWrite, 8'(59 + 60 * $urandom_range(0, 3)), RegSec);
        send_item(OpWrite, ($urandom_range(0, 4) != 0) ? 8'(59 + 60 * $urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255)), RegMin);
        send_item(OpWrite, ($urandom_range(0, 4) != 0) ? 8'(23 + 24 * $urandom_range(0, 9))
                                                       : 8'($urandom_range(0, 255)), RegHour);
        if ($urandom_range(0, 3) != 0) begin
            send_item(OpWrite, flag_byte, RegFlags);
            send_item(OpWrite, day_low, RegDayLow);
        end else begin
            send_item(OpWrite, day_low, RegDayLow);
            send_item(OpWrite, flag_byte, RegFlags);
        end
        send_ticks($urandom_range(55, 125));
        latch_snapshot();
    endtask

    initial begin
        int next_drain;
        int pick;
        logic [3:0] sel;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.opcode     = OpTick;
        in_if.data       = 8'd0;
        in_if.reg_select = 4'd0;
        out_if.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OpTick, 8'h00, 4'h0);
        send_item(OpLatch, 8'h01, 4'h0);
        send_item(OpLatch, 8'hFF, 4'hF);
        send_item(OpLatch, 8'hFE, 4'h0);
        send_item(OpWrite, 8'hFF, RegSec);
        send_item(OpWrite, 8'h00, RegMin);
        send_item(OpWrite, 8'hFF, RegHour);
        send_item(OpWrite, 8'hFF, RegDayLow);
        send_item(OpWrite, 8'h01, RegFlags);
        send_item(OpWrite, 8'h00, RegDayLow);
        send_item(OpWrite, 8'h40, RegFlags);
        send_item(OpTick, 8'hFF, 4'hF);
        send_item(OpWrite, 8'hAA, 4'h0);
        send_item(OpWrite, 8'h55, 4'hF);
        send_item(OpUnused, 8'hFF, 4'hF);
        send_item(OpUnused, 8'h00, 4'h0);
        send_item(OpWrite, 8'h80, RegFlags);
        send_item(OpWrite, 8'h00, RegFlags);
        send_item(OpWrite, 8'd59, RegSec);
        send_item(OpTick, 8'h00, 4'h0);
        send_item(OpLatch, 8'h00, 4'h0);
        send_item(OpLatch, 8'h01, 4'h0);
        drain_results();

        next_drain = items_sent + 400;
        while (items_sent < RandomItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_ticks($urandom_range(1, 80));
            end else if (pick < 55) begin
                run_rollover();
            end else if (pick < 70) begin
                latch_snapshot();
            end else if (pick < 88) begin
                sel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'(8 + $urandom_range(0, 4));
                send_item(OpWrite, 8'($urandom_range(0, 255)), sel);
            end else begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)));
            end
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain = items_sent + 400;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d ticks, %0d latch writes, %0d register writes, %0d unused opcodes.",
                 tracker.ticks, tracker.latches, tracker.writes, tracker.unused_ops);
        $display("Checked %0d results across %0d day wraps; %0d mismatches.",
                 tracker.results_seen, tracker.day_wraps, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_views.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[cartridge_rtc_counter_latch.f]
+incdir+design
design/crtc_pkg.sv
design/crtc_in_if.sv
design/crtc_out_if.sv
design/cartridge_rtc_counter_latch.sv
design/crtc_checker.sv
tb/tb_cartridge_rtc_counter_latch.sv
